// ===== design/rped_pkg.sv =====
package rped_pkg;

    localparam int LENGTH_BITS_DEF = 24;
    localparam int FIFO_DEPTH_DEF  = 4;
    localparam int CFG_ADDR_W      = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_EXPECTED_SIZE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_BUFFER_SIZE   = 1'b1;

    typedef enum logic {
        OP_TOKEN,
        OP_ERR
    } t_op_kind;

    // One unit of work for the back end.
    // fin:  last op of the stream, closes it.
    // look: first of a literal pair at end of stream, a single-copy literal with fin follows.
    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] value;
        logic [7:0] count;
        logic       fin;
        logic       look;
    } t_op;

    function automatic t_op mk_token(input logic [7:0] value, input logic [7:0] count,
                                     input logic fin, input logic look);
        t_op op;
        op.kind  = OP_TOKEN;
        op.value = value;
        op.count = count;
        op.fin   = fin;
        op.look  = look;
        return op;
    endfunction

endpackage

// ===== design/rped_front.sv =====
module rped_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    input  logic           i_size_err,
    input  logic           i_fifo_ready,
    output logic           o_push,
    output rped_pkg::t_op  o_push_op
);

    logic [7:0]    r_pend,   n_pend;
    logic [1:0]    r_level,  n_level;
    logic          r_hold_v, n_hold_v;
    rped_pkg::t_op r_hold_op, n_hold_op;
    logic          accept;

    assign o_s_tready = !r_hold_v && i_fifo_ready;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_pend    = r_pend;
        n_level   = r_level;
        n_hold_v  = r_hold_v;
        n_hold_op = r_hold_op;
        o_push    = 1'b0;
        o_push_op = rped_pkg::mk_token(8'd0, 8'd0, 1'b0, 1'b0);
        if (r_hold_v) begin
            o_push    = 1'b1;
            o_push_op = r_hold_op;
            if (i_fifo_ready) begin
                n_hold_v = 1'b0;
            end
        end else if (accept) begin
            if (i_size_err) begin
                // bytes are dropped; only the last one produces an error marker
                if (i_last) begin
                    o_push         = 1'b1;
                    o_push_op      = rped_pkg::mk_token(8'd0, 8'd0, 1'b1, 1'b0);
                    o_push_op.kind = rped_pkg::OP_ERR;
                    n_pend         = '0;
                    n_level        = '0;
                end
            end else begin
                unique case (r_level)
                    2'd1: begin
                        if (i_byte == r_pend && !i_last) begin
                            n_level = 2'd2;
                        end else if (i_last) begin
                            // two literals; the second waits in the hold register
                            o_push    = 1'b1;
                            o_push_op = rped_pkg::mk_token(r_pend, 8'd1, 1'b0, 1'b1);
                            n_hold_v  = 1'b1;
                            n_hold_op = rped_pkg::mk_token(i_byte, 8'd1, 1'b1, 1'b0);
                            n_pend    = '0;
                            n_level   = '0;
                        end else begin
                            o_push    = 1'b1;
                            o_push_op = rped_pkg::mk_token(r_pend, 8'd1, 1'b0, 1'b0);
                            n_pend    = i_byte;
                        end
                    end
                    2'd2: begin
                        o_push    = 1'b1;
                        o_push_op = rped_pkg::mk_token(r_pend, i_byte, i_last, 1'b0);
                        n_pend    = '0;
                        n_level   = '0;
                    end
                    default: begin
                        if (i_last) begin
                            o_push    = 1'b1;
                            o_push_op = rped_pkg::mk_token(i_byte, 8'd1, 1'b1, 1'b0);
                            n_pend    = '0;
                            n_level   = '0;
                        end else begin
                            n_pend  = i_byte;
                            n_level = 2'd1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= '0;
            r_level  <= '0;
            r_hold_v <= 1'b0;
        end else begin
            r_pend   <= n_pend;
            r_level  <= n_level;
            r_hold_v <= n_hold_v;
        end
        r_hold_op <= n_hold_op;
    end

endmodule

// ===== design/rped_op_fifo.sv =====
module rped_op_fifo #(
    parameter int FIFO_DEPTH = rped_pkg::FIFO_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rped_pkg::t_op i_push_op,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output rped_pkg::t_op o_head
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);

    rped_pkg::t_op    r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_push, do_pop;

    assign o_ready = r_count < CNT_W'(FIFO_DEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_op;
        end
    end

endmodule

// ===== design/rped_back.sv =====
module rped_back #(
    parameter int LENGTH_BITS = rped_pkg::LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [LENGTH_BITS-1:0] i_expected_size,
    input  logic [LENGTH_BITS-1:0] i_buffer_size,
    input  logic                   i_op_valid,
    input  rped_pkg::t_op          i_op,
    output logic                   o_pop,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [7:0]             o_value,
    output logic [7:0]             o_count,
    output logic                   o_end,
    output logic [LENGTH_BITS-1:0] o_length,
    output logic                   o_err
);

    logic [LENGTH_BITS-1:0] r_wt, n_wt;
    logic                   r_limit, n_limit;
    logic                   r_prev_emit, n_prev_emit;

    logic                   r_out_valid, n_out_valid;
    logic [7:0]             r_value, n_value;
    logic [7:0]             r_count, n_count;
    logic                   r_end, n_end;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic                   r_err, n_err;

    logic                   out_free;
    logic                   active;
    logic [LENGTH_BITS-1:0] room;
    logic [7:0]             clip;
    logic                   emit;
    logic [LENGTH_BITS-1:0] wt_sum;
    logic                   lim_sum;
    logic                   next_emit;
    logic                   load;

    assign out_free = !r_out_valid || i_m_tready;
    assign o_pop    = i_op_valid && out_free;

    assign active    = !r_limit && (r_wt < i_expected_size);
    assign room      = (i_buffer_size > r_wt) ? i_buffer_size - r_wt : '0;
    assign clip      = (room < LENGTH_BITS'(i_op.count)) ? room[7:0] : i_op.count;
    assign emit      = (i_op.kind == rped_pkg::OP_TOKEN) && active && (clip != 8'd0);
    assign wt_sum    = r_wt + LENGTH_BITS'(clip);
    assign lim_sum   = wt_sum >= i_expected_size;
    // would the closing literal that follows this one still produce output
    assign next_emit = !lim_sum && (i_buffer_size > wt_sum);

    always_comb begin
        n_wt        = r_wt;
        n_limit     = r_limit;
        n_prev_emit = r_prev_emit;
        n_value     = r_value;
        n_count     = r_count;
        n_end       = r_end;
        n_len       = r_len;
        n_err       = r_err;
        load        = 1'b0;
        if (o_pop) begin
            unique case (i_op.kind)
                rped_pkg::OP_ERR: begin
                    load    = 1'b1;
                    n_value = 8'd0;
                    n_count = 8'd0;
                    n_end   = 1'b1;
                    n_len   = '0;
                    n_err   = 1'b1;
                end
                rped_pkg::OP_TOKEN: begin
                    if (emit) begin
                        load    = 1'b1;
                        n_value = i_op.value;
                        n_count = clip;
                        n_end   = i_op.fin || (i_op.look && !next_emit);
                        n_len   = wt_sum;
                        n_err   = 1'b0;
                        n_wt    = wt_sum;
                        n_limit = lim_sum;
                    end else if (i_op.fin && !r_prev_emit) begin
                        // nothing came out of the final request: bare end marker
                        load    = 1'b1;
                        n_value = 8'd0;
                        n_count = 8'd0;
                        n_end   = 1'b1;
                        n_len   = r_wt;
                        n_err   = 1'b0;
                    end
                end
                default: begin
                    load = 1'b0;
                end
            endcase
            n_prev_emit = i_op.look && emit;
            if (i_op.fin) begin
                n_wt        = '0;
                n_limit     = 1'b0;
                n_prev_emit = 1'b0;
            end
        end
        n_out_valid = o_pop ? load : (r_out_valid && !i_m_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wt        <= '0;
            r_limit     <= 1'b0;
            r_prev_emit <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wt        <= n_wt;
            r_limit     <= n_limit;
            r_prev_emit <= n_prev_emit;
            r_out_valid <= n_out_valid;
        end
        r_value <= n_value;
        r_count <= n_count;
        r_end   <= n_end;
        r_len   <= n_len;
        r_err   <= n_err;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_value    = r_value;
    assign o_count    = r_count;
    assign o_end      = r_end;
    assign o_length   = r_len;
    assign o_err      = r_err;

endmodule

// ===== design/rle_pair_escape_decoder_top.sv =====
// Run-length decoder for the repeated-pair escape format.
// Slave stream: one compressed byte per request in tdata, tlast on the final byte.
// Master stream: one run descriptor per request: value, repeat count and the decoded
// length so far in tdata, tlast on the final descriptor of a stream, tuser set when
// the expected size exceeds the buffer size (then only an end marker comes out).
// Configuration channel: index 0 writes the expected size, index 1 the buffer size;
// write only while no stream is in flight.
// With an empty queue a descriptor reaches the master side through the queue and
// the output register once the byte that completes it is accepted. Throughput: one
// byte per cycle while the queue has room; a final byte that closes two literals
// holds off the next byte while the second literal is held, since the front end
// pushes one operation per cycle into the queue and the back end pops one per cycle.
// A stall on the master side holds the output register; the operation queue
// (FIFO_DEPTH entries) absorbs the front end until it fills, then tready drops.
// Reset clears the configuration to zero, the pending bytes, the queue and the
// running length; the block is ready to accept bytes as soon as reset is released.
module rle_pair_escape_decoder_top #(
    parameter int LENGTH_BITS = rped_pkg::LENGTH_BITS_DEF,
    parameter int FIFO_DEPTH  = rped_pkg::FIFO_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,   // [7:0] in_byte
    input  logic                            i_s_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [7:0] out_value, [15:8] repeat_count, [LENGTH_BITS+15:16] length_so_far
    output logic [((LENGTH_BITS+23)/8)*8-1:0] o_m_tdata,
    output logic                            o_m_tlast,
    output logic                            o_m_tuser,   // [0] size_error
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rped_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [LENGTH_BITS-1:0]          i_cfg_data
);

    localparam int TDATA_W = ((LENGTH_BITS + 23) / 8) * 8;

    logic [LENGTH_BITS-1:0] r_expected_size;
    logic [LENGTH_BITS-1:0] r_buffer_size;
    logic                   size_err;

    logic                   fifo_ready;
    logic                   push;
    rped_pkg::t_op          push_op;
    logic                   op_valid;
    rped_pkg::t_op          head_op;
    logic                   pop;

    logic [7:0]             res_value;
    logic [7:0]             res_count;
    logic [LENGTH_BITS-1:0] res_length;

    assign o_cfg_ready = 1'b1;
    assign size_err    = r_expected_size > r_buffer_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_size <= '0;
            r_buffer_size   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_addr)
                rped_pkg::REG_EXPECTED_SIZE: r_expected_size <= i_cfg_data;
                rped_pkg::REG_BUFFER_SIZE:   r_buffer_size   <= i_cfg_data;
                default:                     r_buffer_size   <= r_buffer_size;
            endcase
        end
    end

    rped_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_byte       (i_s_tdata),
        .i_last       (i_s_tlast),
        .i_size_err   (size_err),
        .i_fifo_ready (fifo_ready),
        .o_push       (push),
        .o_push_op    (push_op)
    );

    rped_op_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_op (push_op),
        .o_ready   (fifo_ready),
        .i_pop     (pop),
        .o_valid   (op_valid),
        .o_head    (head_op)
    );

    rped_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_expected_size (r_expected_size),
        .i_buffer_size   (r_buffer_size),
        .i_op_valid      (op_valid),
        .i_op            (head_op),
        .o_pop           (pop),
        .o_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .o_value         (res_value),
        .o_count         (res_count),
        .o_end           (o_m_tlast),
        .o_length        (res_length),
        .o_err           (o_m_tuser)
    );

    assign o_m_tdata = TDATA_W'({res_length, res_count, res_value});

`ifndef NO_ASSERTIONS
    a_err_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast && (res_length == '0) && (res_count == 8'd0))
        else $error("size error result is not a bare end marker");

    a_zero_count_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (res_count == 8'd0) |-> o_m_tlast)
        else $error("zero-count descriptor in the middle of a stream");

    a_within_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> res_length <= r_buffer_size)
        else $error("decoded length exceeds buffer size");

    a_pop_needs_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> op_valid)
        else $error("back end took an operation from an empty queue");
`endif

endmodule

// ===== sim/rle_pair_escape_decoder_top_tb.sv =====
`timescale 1ns / 100ps

module rle_pair_escape_decoder_top_tb;

    localparam int LEN_W       = 24;
    localparam int TDATA_W     = ((LEN_W + 23) / 8) * 8;
    localparam int DRAIN_WAIT  = 8;
    localparam int STALL_LIMIT = 300;
    localparam int ITEM_GOAL   = 1200;

    typedef struct packed {
        logic [7:0]       value;
        logic [7:0]       count;
        logic             fin;
        logic [LEN_W-1:0] len;
        logic             err;
    } t_run_desc;

    typedef enum logic {
        ROW_BYTE,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind                       kind;
        logic [rped_pkg::CFG_ADDR_W-1:0] addr;
        logic [LEN_W-1:0]                data;
        logic [7:0]                      b;
        logic                            last;
        logic                            typed;
        t_run_desc                       res;
    } t_plan_row;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_s_tvalid  = 1'b0;
    logic                            o_s_tready;
    logic [7:0]                      i_s_tdata   = '0;
    logic                            i_s_tlast   = 1'b0;
    logic                            o_m_tvalid;
    logic                            i_m_tready  = 1'b0;
    logic [TDATA_W-1:0]              o_m_tdata;
    logic                            o_m_tlast;
    logic                            o_m_tuser;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [rped_pkg::CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [LEN_W-1:0]                i_cfg_data  = '0;

    rle_pair_escape_decoder_top #(
        .LENGTH_BITS(LEN_W)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // decoder model state
    logic [LEN_W-1:0] exp_size;
    logic [LEN_W-1:0] cap_size;
    logic [7:0]       held_byte;
    logic [1:0]       held_level;
    logic [LEN_W-1:0] decoded_len;
    logic             done_flag;

    t_run_desc step_runs[$];
    t_run_desc expected_runs[$];

    int  mismatches   = 0;
    int  runs_checked = 0;
    int  bytes_sent   = 0;
    int  active_items = 0;
    int  streams_done = 0;
    int  size_errors  = 0;
    int  cfg_writes   = 0;
    int  stall_count  = 0;
    bit  calm         = 1'b0;

    function automatic void clear_stream();
        held_byte   = '0;
        held_level  = '0;
        decoded_len = '0;
        done_flag   = 1'b0;
    endfunction

    // Append a run of c copies of v, clamped to the space left in the buffer.
    function automatic void add_run(input logic [7:0] v, input logic [7:0] c);
        logic [LEN_W:0] room;
        logic [LEN_W:0] n;
        t_run_desc      r;
        if (done_flag || decoded_len >= exp_size)
            return;
        room = (cap_size > decoded_len) ? {1'b0, cap_size - decoded_len} : '0;
        n    = (LEN_W+1)'(c);
        if (n > room)
            n = room;
        if (n == 0)
            return;
        decoded_len = decoded_len + n[LEN_W-1:0];
        if (decoded_len >= exp_size)
            done_flag = 1'b1;
        r = '{value: v, count: n[7:0], fin: 1'b0, len: decoded_len, err: 1'b0};
        step_runs.push_back(r);
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic last);
        t_run_desc r;
        step_runs.delete();
        if (exp_size > cap_size) begin
            if (last) begin
                r = '{value: 8'h00, count: 8'h00, fin: 1'b1, len: '0, err: 1'b1};
                step_runs.push_back(r);
                clear_stream();
            end
            return;
        end
        case (held_level)
            2'd1: begin
                if (b == held_byte && !last) begin
                    held_level = 2'd2;
                end else begin
                    add_run(held_byte, 8'd1);
                    if (last) begin
                        add_run(b, 8'd1);
                    end else begin
                        held_byte  = b;
                        held_level = 2'd1;
                    end
                end
            end
            2'd2: begin
                add_run(held_byte, b);
                held_level = '0;
                held_byte  = '0;
            end
            default: begin
                if (last) begin
                    add_run(b, 8'd1);
                end else begin
                    held_byte  = b;
                    held_level = 2'd1;
                end
            end
        endcase
        if (last) begin
            if (step_runs.size() > 0) begin
                r     = step_runs[$];
                r.fin = 1'b1;
                step_runs[$] = r;
            end else begin
                r = '{value: 8'h00, count: 8'h00, fin: 1'b1, len: decoded_len, err: 1'b0};
                step_runs.push_back(r);
            end
            clear_stream();
        end
    endfunction

    // Leaves tvalid high after the request is taken; callers lower it when the stream pauses.
    task automatic push_byte(input logic [7:0] b, input logic last, input logic use_given,
                             input t_run_desc given);
        while (!calm && $urandom_range(0, 99) < 17) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        if (exp_size <= cap_size && !done_flag && decoded_len < exp_size)
            active_items++;
        decode_byte(b, last);
        if (use_given)
            expected_runs.push_back(given);
        else
            foreach (step_runs[k])
                expected_runs.push_back(step_runs[k]);
        bytes_sent++;
        if (last) begin
            streams_done++;
            if (exp_size > cap_size)
                size_errors++;
        end
    endtask

    task automatic write_reg(input logic [rped_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [LEN_W-1:0] val);
        i_s_tvalid <= 1'b0;
        while (expected_runs.size() != 0)
            @(posedge i_clk);
        // bytes that produce nothing may still be in the pipe
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == rped_pkg::REG_EXPECTED_SIZE)
            exp_size = val;
        else
            cap_size = val;
        cfg_writes++;
    endtask

    // output side: random back-pressure and checking
    always @(posedge i_clk) begin
        t_run_desc got;
        t_run_desc want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{value: o_m_tdata[7:0], count: o_m_tdata[15:8], fin: o_m_tlast,
                    len: o_m_tdata[LEN_W+15:16], err: o_m_tuser};
            if (expected_runs.size() == 0) begin
                mismatches++;
                $display({"%0t expected no run, got value=%02h count=%0d end=%0b len=%0d",
                          " err=%0b"},
                         $time, got.value, got.count, got.fin, got.len, got.err);
            end else begin
                want = expected_runs.pop_front();
                runs_checked++;
                if (got.value !== want.value || got.count !== want.count ||
                    got.fin !== want.fin || got.len !== want.len || got.err !== want.err) begin
                    mismatches++;
                    $display({"%0t mismatch: expected value=%02h count=%0d end=%0b len=%0d",
                              " err=%0b, got value=%02h count=%0d end=%0b len=%0d err=%0b"},
                             $time, want.value, want.count, want.fin, want.len, want.err,
                             got.value, got.count, got.fin, got.len, got.err);
                end
            end
        end
        i_m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 17);
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("%0t no progress for %0d cycles, %0d runs outstanding",
                     $time, STALL_LIMIT, expected_runs.size());
            $display("status: fail");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    initial begin
        t_plan_row   plan[$];
        t_run_desc   none;
        logic [7:0]  stream_q[$];
        logic [7:0]  v;
        logic [23:0] e;
        logic [23:0] s;
        int          phase;
        int          phase_bytes;
        int          budget;
        int          n_tok;
        bit          noise;

        none = '0;
        exp_size = '0;
        cap_size = '0;
        clear_stream();

        plan = '{
            // end marker straight after reset
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'h00, 1'b1, 1'b1,
              '{8'h00, 8'd0, 1'b1, 24'd0, 1'b0}},
            '{ROW_CFG, rped_pkg::REG_EXPECTED_SIZE, 24'd1000, 8'h00, 1'b0, 1'b0, none},
            '{ROW_CFG, rped_pkg::REG_BUFFER_SIZE, 24'd1000, 8'h00, 1'b0, 1'b0, none},
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'hFF, 1'b0, 1'b0, none},
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'hFF, 1'b0, 1'b0, none},
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'hFF, 1'b0, 1'b1,
              '{8'hFF, 8'd255, 1'b0, 24'd255, 1'b0}},
            // zero-count run
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'h00, 1'b0, 1'b0, none},
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'h00, 1'b0, 1'b0, none},
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'h00, 1'b0, 1'b0, none},
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'h41, 1'b0, 1'b0, none},
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'h42, 1'b0, 1'b0, none},
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'h42, 1'b0, 1'b0, none},
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'h03, 1'b0, 1'b0, none},
            // pair in the last two bytes: two literals
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'h10, 1'b0, 1'b0, none},
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'h10, 1'b1, 1'b0, none},
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'h07, 1'b0, 1'b0, none},
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'h07, 1'b0, 1'b0, none},
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'h05, 1'b1, 1'b1,
              '{8'h07, 8'd5, 1'b1, 24'd5, 1'b0}},
            // zero-count run closing the stream: bare end marker
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'h09, 1'b0, 1'b0, none},
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'h09, 1'b0, 1'b0, none},
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'h00, 1'b1, 1'b1,
              '{8'h00, 8'd0, 1'b1, 24'd0, 1'b0}},
            // clamp to the buffer, then decoding finished
            '{ROW_CFG, rped_pkg::REG_EXPECTED_SIZE, 24'd4, 8'h00, 1'b0, 1'b0, none},
            '{ROW_CFG, rped_pkg::REG_BUFFER_SIZE, 24'd4, 8'h00, 1'b0, 1'b0, none},
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'h61, 1'b0, 1'b0, none},
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'h61, 1'b0, 1'b0, none},
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'h09, 1'b0, 1'b1,
              '{8'h61, 8'd4, 1'b0, 24'd4, 1'b0}},
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'h62, 1'b0, 1'b0, none},
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'h63, 1'b1, 1'b1,
              '{8'h00, 8'd0, 1'b1, 24'd4, 1'b0}},
            // expected size above buffer size
            '{ROW_CFG, rped_pkg::REG_EXPECTED_SIZE, 24'd10, 8'h00, 1'b0, 1'b0, none},
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'h33, 1'b0, 1'b0, none},
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'h33, 1'b1, 1'b1,
              '{8'h00, 8'd0, 1'b1, 24'd0, 1'b1}},
            '{ROW_CFG, rped_pkg::REG_BUFFER_SIZE, 24'hFFFFFF, 8'h00, 1'b0, 1'b0, none},
            '{ROW_CFG, rped_pkg::REG_EXPECTED_SIZE, 24'hFFFFFF, 8'h00, 1'b0, 1'b0, none},
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'h5A, 1'b0, 1'b0, none},
            '{ROW_BYTE, rped_pkg::REG_EXPECTED_SIZE, 24'd0, 8'hA5, 1'b1, 1'b0, none}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG)
                write_reg(plan[k].addr, plan[k].data);
            else
                push_byte(plan[k].b, plan[k].last, plan[k].typed, plan[k].res);
        end

        phase = 0;
        while (bytes_sent < ITEM_GOAL && phase < 60) begin
            case (phase % 6)
                0: begin
                    e = 24'hFFFFFF;
                    s = 24'hFFFFFF;
                end
                1: begin
                    e = 24'($urandom_range(50, 600));
                    s = e;
                end
                2: begin
                    e = 24'($urandom_range(1, 300));
                    s = 24'($urandom_range(e, 24'hFFFFFF));
                end
                3: begin
                    e = '0;
                    s = '0;
                end
                4: begin
                    s = 24'($urandom_range(0, 2000));
                    e = 24'($urandom_range(s + 1, 24'hFFFFFF));
                end
                default: begin
                    e = 24'($urandom_range(1000, 24'hFFFFFF));
                    s = 24'hFFFFFF;
                end
            endcase
            write_reg(rped_pkg::REG_EXPECTED_SIZE, e);
            write_reg(rped_pkg::REG_BUFFER_SIZE, s);
            calm   = (phase == 2);
            budget = (phase % 6 == 3 || phase % 6 == 4) ? 40 : 200;
            phase_bytes = 0;
            while (phase_bytes < budget && bytes_sent < ITEM_GOAL) begin
                stream_q.delete();
                n_tok = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
                noise = ($urandom_range(0, 9) == 0);
                for (int t = 0; t < n_tok; t++) begin
                    v = 8'($urandom);
                    if (noise) begin
                        stream_q.push_back(8'($urandom_range(0, 3)));
                    end else if ($urandom_range(0, 99) < 55) begin
                        if (stream_q.size() > 0 && v == stream_q[$])
                            v = ~v;
                        stream_q.push_back(v);
                    end else begin
                        if (stream_q.size() > 0 && v == stream_q[$])
                            v = ~v;
                        stream_q.push_back(v);
                        stream_q.push_back(v);
                        stream_q.push_back(8'(($urandom_range(0, 3) == 0)
                                              ? $urandom_range(0, 255)
                                              : $urandom_range(0, 8)));
                    end
                end
                // cut the stream short now and then, e.g. in the middle of a run
                if ($urandom_range(0, 4) == 0 && stream_q.size() > 1)
                    void'(stream_q.pop_back());
                foreach (stream_q[k])
                    push_byte(stream_q[k], k == stream_q.size() - 1, 1'b0, none);
                phase_bytes += stream_q.size();
            end
            calm = 1'b0;
            phase++;
        end

        i_s_tvalid <= 1'b0;
        while (expected_runs.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("covered %0d bytes (%0d while decoding) in %0d streams, %0d size-error streams",
                 bytes_sent, active_items, streams_done, size_errors);
        $display("checked %0d run descriptors over %0d register writes, %0d mismatches",
                 runs_checked, cfg_writes, mismatches);
        if (mismatches == 0 && expected_runs.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
